/* hdl/ctus_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ctus_pkg;

  // Field widths
  localparam int CycW  = 64;
  localparam int PmW   = 32;
  localparam int RateW = 34;
  localparam int UsW   = 64;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = RateW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_USE_CYCLE_COUNTER = 2'd0,
    CFG_CYCLE_RATE_HZ     = 2'd1,
    CFG_WIDE_PM_COUNTER   = 2'd2,
    CFG_PM_PRESENT        = 2'd3
  } cfg_idx_e;

  // Constants
  localparam logic [PmW-1:0] Mask24   = 32'h00FF_FFFF;
  localparam logic [PmW-1:0] Mask32   = 32'hFFFF_FFFF;
  localparam int             UsPerSW  = 20;
  localparam logic [UsPerSW-1:0] UsPerS = 20'd1000000;
  localparam logic [PmW-1:0] PmFreqHz = 32'd3579545;

  // Multiplier: 34-bit operand times the 20-bit microseconds-per-second constant
  localparam int ProdW = RateW + UsPerSW;

  // Serial divider: two quotient bits per cycle over a 64-bit dividend
  localparam int DivBitsPerCycle = 2;
  localparam int DivCycles       = CycW / DivBitsPerCycle;
  localparam int DivCntW         = $clog2(DivCycles);

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_DIV     = 3'd2,
    OP_MUL_LO  = 3'd3,
    OP_MUL_HI  = 3'd4,
    OP_MUL_REM = 3'd5,
    OP_LOAD2   = 3'd6
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_DIV1    = 3'd1,
    ST_MUL_LO  = 3'd2,
    ST_MUL_HI  = 3'd3,
    ST_MUL_REM = 3'd4,
    ST_LOAD2   = 3'd5,
    ST_DIV2    = 3'd6,
    ST_FIN     = 3'd7
  } state_e;

endpackage

`default_nettype wire

/* hdl/ctus_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctus_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire ctus_pkg::dp_stat_t stat_i,
  output ctus_pkg::dp_cmd_t       cmd_o
);

  ctus_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ctus_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctus_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ctus_pkg::ST_DIV1;
      end
      ctus_pkg::ST_DIV1: begin
        if (stat_i.div_last) state_d = ctus_pkg::ST_MUL_LO;
      end
      ctus_pkg::ST_MUL_LO:  state_d = ctus_pkg::ST_MUL_HI;
      ctus_pkg::ST_MUL_HI:  state_d = ctus_pkg::ST_MUL_REM;
      ctus_pkg::ST_MUL_REM: state_d = ctus_pkg::ST_LOAD2;
      ctus_pkg::ST_LOAD2:   state_d = ctus_pkg::ST_DIV2;
      ctus_pkg::ST_DIV2: begin
        if (stat_i.div_last) state_d = ctus_pkg::ST_FIN;
      end
      ctus_pkg::ST_FIN: begin
        if (out_free) state_d = ctus_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op       = ctus_pkg::OP_NONE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ctus_pkg::ST_IDLE: begin
        if (in_valid_i) cmd_o.op = ctus_pkg::OP_LOAD;
      end
      ctus_pkg::ST_DIV1:    cmd_o.op = ctus_pkg::OP_DIV;
      ctus_pkg::ST_MUL_LO:  cmd_o.op = ctus_pkg::OP_MUL_LO;
      ctus_pkg::ST_MUL_HI:  cmd_o.op = ctus_pkg::OP_MUL_HI;
      ctus_pkg::ST_MUL_REM: cmd_o.op = ctus_pkg::OP_MUL_REM;
      ctus_pkg::ST_LOAD2:   cmd_o.op = ctus_pkg::OP_LOAD2;
      ctus_pkg::ST_DIV2:    cmd_o.op = ctus_pkg::OP_DIV;
      ctus_pkg::ST_FIN:     cmd_o.out_load = out_free;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctus_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  // Never overwrite a word that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free)
    else $error("result register overwritten while full");

  // An accepted word starts the first divide pass
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ctus_pkg::ST_DIV1))
    else $error("accepted word did not start the divider");

  // Second divide pass ends in the finish state
  a_div2_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ctus_pkg::ST_DIV2 && stat_i.div_last) |=> (state_q == ctus_pkg::ST_FIN))
    else $error("second divide pass did not finish");

  // A new result only appears after the finish state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ctus_pkg::ST_FIN))
    else $error("result raised outside the finish state");
`endif

endmodule

`default_nettype wire

/* hdl/ctus_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctus_datapath #(
  parameter logic [ctus_pkg::PmW-1:0] PM_FREQ_HZ = ctus_pkg::PmFreqHz
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [ctus_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ctus_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic [ctus_pkg::CycW-1:0]     cycle_sample_i,
  input  wire logic [ctus_pkg::PmW-1:0]      pm_sample_i,
  input  wire logic                          start_req_i,
  input  wire ctus_pkg::dp_cmd_t             cmd_i,
  output ctus_pkg::dp_stat_t                 stat_o,
  output logic [ctus_pkg::UsW-1:0]           microseconds_o
);

  localparam int CycW  = ctus_pkg::CycW;
  localparam int PmW   = ctus_pkg::PmW;
  localparam int RateW = ctus_pkg::RateW;
  localparam int ProdW = ctus_pkg::ProdW;

  typedef struct packed {
    logic [RateW-1:0] rem;
    logic [CycW-1:0]  num;
  } div_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic div_t div_step(div_t s, logic [RateW-1:0] d);
    logic [RateW:0] trial;
    logic           fits;
    div_t           r;
    trial = {s.rem, s.num[CycW-1]};
    fits  = (trial >= {1'b0, d});
    if (fits) trial = trial - {1'b0, d};
    r.rem = trial[RateW-1:0];
    r.num = {s.num[CycW-2:0], fits};
    return r;
  endfunction

  // Configuration
  logic             use_cc_q, wide_pm_q, pm_present_q;
  logic [RateW-1:0] rate_q;

  // Timer state
  logic [PmW-1:0]  last_pm_q, last_pm_d;
  logic [CycW-1:0] pm_total_q, pm_total_d;

  // Working registers
  logic [RateW-1:0]             divisor_q, divisor_d;
  logic [RateW-1:0]             rem_q, rem_d;
  logic [CycW-1:0]              num_q, num_d;
  logic [CycW-1:0]              acc_q, acc_d;
  logic [ProdW-1:0]             prod_q, prod_d;
  logic [ctus_pkg::UsW-1:0]     out_q;
  logic [ctus_pkg::DivCntW-1:0] cnt_q, cnt_d;

  logic [PmW-1:0]   mask, pm_now, last_eff, delta;
  logic [CycW-1:0]  total_eff, total_new;
  logic [RateW-1:0] mul_a;
  div_t             step0, step1, step2;

  assign mask      = wide_pm_q ? ctus_pkg::Mask32 : ctus_pkg::Mask24;
  assign pm_now    = pm_sample_i & mask;
  assign last_eff  = start_req_i ? pm_now : last_pm_q;
  assign total_eff = start_req_i ? '0 : pm_total_q;
  assign delta     = (pm_now - last_eff) & mask;
  assign total_new = total_eff + {{(CycW-PmW){1'b0}}, delta};

  assign step0 = '{rem: rem_q, num: num_q};
  assign step1 = div_step(step0, divisor_q);
  assign step2 = div_step(step1, divisor_q);

  always_comb begin
    case (cmd_i.op)
      ctus_pkg::OP_MUL_LO: mul_a = {{(RateW-32){1'b0}}, num_q[31:0]};
      ctus_pkg::OP_MUL_HI: mul_a = {{(RateW-32){1'b0}}, num_q[63:32]};
      default:             mul_a = rem_q;
    endcase
  end

  assign prod_d = ProdW'(mul_a * ctus_pkg::UsPerS);

  always_comb begin
    last_pm_d  = last_pm_q;
    pm_total_d = pm_total_q;
    divisor_d  = divisor_q;
    rem_d      = rem_q;
    num_d      = num_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    case (cmd_i.op)
      ctus_pkg::OP_LOAD: begin
        rem_d = '0;
        cnt_d = '0;
        if (use_cc_q) begin
          last_pm_d  = last_eff;
          pm_total_d = total_eff;
          num_d      = cycle_sample_i;
          divisor_d  = (rate_q == '0) ? RateW'(1) : rate_q;
        end else if (!pm_present_q) begin
          // Absent PM counter: zero dividend gives a zero result
          last_pm_d  = last_eff;
          pm_total_d = total_eff;
          num_d      = '0;
          divisor_d  = {{(RateW-PmW){1'b0}}, PM_FREQ_HZ};
        end else begin
          last_pm_d  = pm_now;
          pm_total_d = total_new;
          num_d      = total_new;
          divisor_d  = {{(RateW-PmW){1'b0}}, PM_FREQ_HZ};
        end
      end
      ctus_pkg::OP_DIV: begin
        rem_d = step2.rem;
        num_d = step2.num;
        cnt_d = cnt_q + 1'b1;
      end
      ctus_pkg::OP_MUL_HI:  acc_d = {{(CycW-ProdW){1'b0}}, prod_q};
      ctus_pkg::OP_MUL_REM: acc_d = acc_q + {prod_q[31:0], 32'd0};
      ctus_pkg::OP_LOAD2: begin
        num_d = {{(CycW-ProdW){1'b0}}, prod_q};
        rem_d = '0;
        cnt_d = '0;
      end
      default: ;
    endcase
  end

  assign stat_o.div_last = (cnt_q == '1);
  assign microseconds_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_cc_q     <= 1'b0;
      rate_q       <= RateW'(1);
      wide_pm_q    <= 1'b0;
      pm_present_q <= 1'b0;
      last_pm_q    <= '0;
      pm_total_q   <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (ctus_pkg::cfg_idx_e'(cfg_index_i))
          ctus_pkg::CFG_USE_CYCLE_COUNTER: use_cc_q     <= cfg_data_i[0];
          ctus_pkg::CFG_CYCLE_RATE_HZ:     rate_q       <= cfg_data_i;
          ctus_pkg::CFG_WIDE_PM_COUNTER:   wide_pm_q    <= cfg_data_i[0];
          ctus_pkg::CFG_PM_PRESENT:        pm_present_q <= cfg_data_i[0];
        endcase
      end
      last_pm_q  <= last_pm_d;
      pm_total_q <= pm_total_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    num_q     <= num_d;
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    if (cmd_i.out_load) out_q <= acc_q + num_q;
  end

endmodule

`default_nettype wire

/* hdl/counter_timestamp_to_microseconds.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   cycle_sample_i[63:0], pm_sample_i[31:0], start_req_i
// out      out_valid_o / out_ready_i microseconds_o[63:0]
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i[1:0], cfg_data_i[33:0]
//
// Each word passes through the load step that accepts it, two passes of the
// two-bit-per-cycle serial divider, four multiply and load steps and one finish
// step; the result is registered in the finish step and is valid after it.
// The next word is accepted right after the finish, even while the result waits.
// A full, unread result register holds the block in its finish state.
// Reset clears the timer state and restores register defaults; writes never stall.

module counter_timestamp_to_microseconds #(
  parameter logic [ctus_pkg::PmW-1:0] PM_FREQ_HZ = ctus_pkg::PmFreqHz
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Time read words
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ctus_pkg::CycW-1:0]     cycle_sample_i,
  input  wire logic [ctus_pkg::PmW-1:0]      pm_sample_i,
  input  wire logic                          start_req_i,
  // Result words
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ctus_pkg::UsW-1:0]           microseconds_o,
  // Register writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ctus_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ctus_pkg::CfgDataW-1:0] cfg_data_i
);

  ctus_pkg::dp_cmd_t  cmd;
  ctus_pkg::dp_stat_t stat;

  // Register writes never stall
  assign cfg_ready_o = 1'b1;

  // Sequencer: steps load, divide, multiply and finish
  ctus_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: registers, timer state, divider, multiplier, result register
  ctus_datapath #(
    .PM_FREQ_HZ (PM_FREQ_HZ)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cycle_sample_i (cycle_sample_i),
    .pm_sample_i    (pm_sample_i),
    .start_req_i    (start_req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .microseconds_o (microseconds_o)
  );

endmodule

`default_nettype wire
